// ===== rtl/sfrr_pkg.sv =====
// ----------------------------------------------------------------------------
// sfrr_pkg
// Shared types, codes and defaults of the SPI frame ring receiver.
// ----------------------------------------------------------------------------
package sfrr_pkg;

  localparam int FRAME_BYTES_DEF = 16;
  localparam int RING_SLOTS_DEF  = 8;
  localparam int CNT_W           = 32;
  localparam int NUM_CNT         = 6;

  // event counter slots
  localparam int CNT_TRANS = 0;
  localparam int CNT_OVF   = 1;
  localparam int CNT_BUS   = 2;
  localparam int CNT_REARM = 3;
  localparam int CNT_ACK   = 4;
  localparam int CNT_ABORT = 5;

  // request kinds on the input channel
  localparam logic [3:0] KIND_INIT     = 4'd0;
  localparam logic [3:0] KIND_RX_BYTE  = 4'd1;
  localparam logic [3:0] KIND_COMPLETE = 4'd2;
  localparam logic [3:0] KIND_ERROR    = 4'd3;
  localparam logic [3:0] KIND_ACK      = 4'd4;
  localparam logic [3:0] KIND_ABORT    = 4'd5;
  localparam logic [3:0] KIND_STOP     = 4'd6;
  localparam logic [3:0] KIND_RESUME   = 4'd7;
  localparam logic [3:0] KIND_SERVICE  = 4'd8;
  localparam logic [3:0] KIND_POP      = 4'd9;
  localparam logic [3:0] KIND_QUERY    = 4'd10;

  typedef enum logic [1:0] {
    PH_STOPPED = 2'd0,
    PH_REQUEST = 2'd1,
    PH_DONE    = 2'd2,
    PH_ERROR   = 2'd3
  } phase_t;

  typedef enum logic [3:0] {
    OP_INIT,
    OP_RX,
    OP_COMPLETE,
    OP_ERROR,
    OP_ACK,
    OP_ABORT,
    OP_STOP,
    OP_RESUME,
    OP_SERVICE,
    OP_POP,
    OP_QUERY,
    OP_NOP
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data;
    logic       arm_ok;
    logic       deinit_ok;
    logic       nss_high;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COPY,
    ST_RESP,
    ST_POP_RD,
    ST_POP_EMIT
  } bstate_t;

endpackage

// ===== rtl/sfrr_ram.sv =====
// ----------------------------------------------------------------------------
// sfrr_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module sfrr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/sfrr_front.sv =====
// ----------------------------------------------------------------------------
// sfrr_front
// Accepts input requests, decodes the kind and queues them for the back end.
// ----------------------------------------------------------------------------
module sfrr_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic [3:0]     in_kind,
  input  logic [7:0]     in_rx_data,
  input  logic           in_arm_ok,
  input  logic           in_deinit_ok,
  input  logic           in_nss_high,
  output sfrr_pkg::cmd_t q_cmd,
  output logic           q_valid,
  input  logic           q_pop
);
  import sfrr_pkg::*;

  cmd_t       q_mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  cmd_t       dec_cmd;
  logic       push;

  always_comb begin
    dec_cmd.data      = in_rx_data;
    dec_cmd.arm_ok    = in_arm_ok;
    dec_cmd.deinit_ok = in_deinit_ok;
    dec_cmd.nss_high  = in_nss_high;
    unique case (in_kind)
      KIND_INIT:     dec_cmd.op = OP_INIT;
      KIND_RX_BYTE:  dec_cmd.op = OP_RX;
      KIND_COMPLETE: dec_cmd.op = OP_COMPLETE;
      KIND_ERROR:    dec_cmd.op = OP_ERROR;
      KIND_ACK:      dec_cmd.op = OP_ACK;
      KIND_ABORT:    dec_cmd.op = OP_ABORT;
      KIND_STOP:     dec_cmd.op = OP_STOP;
      KIND_RESUME:   dec_cmd.op = OP_RESUME;
      KIND_SERVICE:  dec_cmd.op = OP_SERVICE;
      KIND_POP:      dec_cmd.op = OP_POP;
      KIND_QUERY:    dec_cmd.op = OP_QUERY;
      default:       dec_cmd.op = OP_NOP;
    endcase
  end

  assign in_stall = (count_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count_r != 2'd0);
  assign q_cmd    = q_mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = q_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !q_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (!push && q_pop) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= dec_cmd;
    end
  end

endmodule

// ===== rtl/sfrr_back.sv =====
// ----------------------------------------------------------------------------
// sfrr_back
// Executes queued requests: phase machine, staging, frame ring, counters.
// ----------------------------------------------------------------------------
module sfrr_back #(
  parameter int FRAME_BYTES = sfrr_pkg::FRAME_BYTES_DEF,
  parameter int RING_SLOTS  = sfrr_pkg::RING_SLOTS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  sfrr_pkg::cmd_t           q_cmd,
  input  logic                     q_valid,
  output logic                     q_pop,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     out_accepted,
  output logic [7:0]               out_frame_byte,
  output logic                     out_last,
  output logic [1:0]               out_phase_now,
  output logic                     out_armed_now,
  output logic                     out_idle_now,
  output logic [sfrr_pkg::CNT_W-1:0] out_transactions,
  output logic [sfrr_pkg::CNT_W-1:0] out_overflows,
  output logic [sfrr_pkg::CNT_W-1:0] out_bus_errors,
  output logic [sfrr_pkg::CNT_W-1:0] out_rearm_errors,
  output logic [sfrr_pkg::CNT_W-1:0] out_acks,
  output logic [sfrr_pkg::CNT_W-1:0] out_ack_aborts
);
  import sfrr_pkg::*;

  localparam int IDX_W   = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
  localparam int FILL_W  = $clog2(FRAME_BYTES + 1);
  localparam int SLOT_W  = $clog2(RING_SLOTS);
  localparam int RING_AW = SLOT_W + IDX_W;

  bstate_t              state_r, state_nxt;
  phase_t               phase_r, phase_nxt;
  logic                 armed_r, armed_nxt;
  logic [FILL_W-1:0]    fill_r, fill_nxt;
  logic [SLOT_W-1:0]    wslot_r, wslot_nxt;
  logic [SLOT_W-1:0]    rslot_r, rslot_nxt;
  logic [SLOT_W-1:0]    slot_r, slot_nxt;
  logic [FILL_W-1:0]    cnt_r, cnt_nxt;
  logic                 acc_r, acc_nxt;
  logic [CNT_W-1:0]     evt_r [NUM_CNT];
  logic [CNT_W-1:0]     evt_nxt [NUM_CNT];
  logic [NUM_CNT-1:0]   inc;

  logic                 out_valid_r, out_valid_nxt;
  logic                 out_load;
  logic                 out_acc_r, out_acc_nxt;
  logic [7:0]           out_byte_r, out_byte_nxt;
  logic                 out_last_r, out_last_nxt;
  logic [1:0]           out_phase_r;
  logic                 out_armed_r;
  logic                 out_idle_r;
  logic [CNT_W-1:0]     out_evt_r [NUM_CNT];

  logic                 out_free, take, ring_full, ring_drained;
  logic                 go_copy, go_pop, last_byte, copy_end, do_arm;
  logic [SLOT_W-1:0]    wslot_inc, rslot_inc;
  logic [FILL_W-1:0]    wr_idx;

  logic                 stg_we;
  logic [IDX_W-1:0]     stg_raddr;
  logic [7:0]           stg_rdata;
  logic                 ring_we;
  logic [RING_AW-1:0]   ring_waddr, ring_raddr;
  logic [7:0]           ring_wdata, ring_rdata;

  sfrr_ram #(.WIDTH(8), .DEPTH(FRAME_BYTES)) u_staging (
    .clk     (clk),
    .wr_en   (stg_we),
    .wr_addr (fill_r[IDX_W-1:0]),
    .wr_data (q_cmd.data),
    .rd_addr (stg_raddr),
    .rd_data (stg_rdata)
  );

  sfrr_ram #(.WIDTH(8), .DEPTH(RING_SLOTS << IDX_W)) u_ring (
    .clk     (clk),
    .wr_en   (ring_we),
    .wr_addr (ring_waddr),
    .wr_data (ring_wdata),
    .rd_addr (ring_raddr),
    .rd_data (ring_rdata)
  );

  assign out_free   = !out_valid_r || !out_stall;
  assign take       = (state_r == ST_IDLE) && q_valid;
  assign q_pop      = take;
  assign wslot_inc  = (wslot_r == SLOT_W'(RING_SLOTS - 1)) ? '0 : wslot_r + 1'b1;
  assign rslot_inc  = (rslot_r == SLOT_W'(RING_SLOTS - 1)) ? '0 : rslot_r + 1'b1;
  assign ring_full  = (wslot_inc == rslot_r);
  assign ring_drained = (wslot_r == rslot_r);
  assign go_copy    = take && (q_cmd.op == OP_COMPLETE) && (phase_r == PH_REQUEST)
                      && !ring_full;
  assign go_pop     = take && (q_cmd.op == OP_POP) && !ring_drained;
  assign last_byte  = (cnt_r == FILL_W'(FRAME_BYTES - 1));
  assign copy_end   = (cnt_r == FILL_W'(FRAME_BYTES));

  // copy: staging read runs one entry ahead of the ring write
  assign wr_idx     = cnt_r - 1'b1;
  assign stg_raddr  = cnt_r[IDX_W-1:0];
  assign ring_waddr = {slot_r, wr_idx[IDX_W-1:0]};
  // entries past the fill count are written to the ring as zero
  assign ring_wdata = (wr_idx < fill_r) ? stg_rdata : 8'd0;
  assign ring_raddr = {slot_r, cnt_r[IDX_W-1:0]};

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (go_copy) begin
          state_nxt = ST_COPY;
        end else if (go_pop) begin
          state_nxt = ST_POP_RD;
        end else if (take) begin
          state_nxt = ST_RESP;
        end
      end
      ST_COPY: begin
        if (copy_end) begin
          state_nxt = ST_RESP;
        end
      end
      ST_RESP: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_POP_RD: state_nxt = ST_POP_EMIT;
      ST_POP_EMIT: begin
        if (out_free) begin
          state_nxt = last_byte ? ST_IDLE : ST_POP_RD;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    phase_nxt    = phase_r;
    armed_nxt    = armed_r;
    fill_nxt     = fill_r;
    wslot_nxt    = wslot_r;
    rslot_nxt    = rslot_r;
    slot_nxt     = slot_r;
    cnt_nxt      = cnt_r;
    acc_nxt      = acc_r;
    inc          = '0;
    do_arm       = 1'b0;
    stg_we       = 1'b0;
    ring_we      = 1'b0;
    out_load     = 1'b0;
    out_acc_nxt  = out_acc_r;
    out_byte_nxt = out_byte_r;
    out_last_nxt = out_last_r;

    unique case (state_r)
      ST_IDLE: begin
        if (take) begin
          acc_nxt = 1'b0;
          unique case (q_cmd.op)
            OP_INIT: begin
              wslot_nxt = '0;
              rslot_nxt = '0;
              do_arm    = 1'b1;
            end
            OP_RX: begin
              if (armed_r && (fill_r < FILL_W'(FRAME_BYTES))) begin
                stg_we   = 1'b1;
                fill_nxt = fill_r + 1'b1;
                acc_nxt  = 1'b1;
              end
            end
            OP_COMPLETE: begin
              armed_nxt      = 1'b0;
              inc[CNT_TRANS] = 1'b1;
              if (phase_r == PH_REQUEST) begin
                if (ring_full) begin
                  inc[CNT_OVF] = 1'b1;
                end else begin
                  slot_nxt  = wslot_r;
                  wslot_nxt = wslot_inc;
                  cnt_nxt   = '0;
                  acc_nxt   = 1'b1;
                end
                phase_nxt = PH_DONE;
              end else begin
                phase_nxt = PH_ERROR;
              end
            end
            OP_ERROR: begin
              armed_nxt    = 1'b0;
              phase_nxt    = PH_ERROR;
              inc[CNT_BUS] = 1'b1;
              acc_nxt      = 1'b1;
            end
            OP_ACK, OP_ABORT: begin
              if ((phase_r == PH_DONE) && !armed_r) begin
                if (q_cmd.op == OP_ACK) begin
                  inc[CNT_ACK] = 1'b1;
                end else begin
                  inc[CNT_ABORT] = 1'b1;
                end
                do_arm = 1'b1;
              end
            end
            OP_STOP: begin
              armed_nxt = 1'b0;
              phase_nxt = PH_STOPPED;
              acc_nxt   = 1'b1;
            end
            OP_RESUME: begin
              if (!q_cmd.deinit_ok) begin
                inc[CNT_REARM] = 1'b1;
              end else begin
                do_arm = 1'b1;
              end
            end
            OP_SERVICE: begin
              if ((phase_r == PH_ERROR) && !armed_r && q_cmd.nss_high) begin
                do_arm = 1'b1;
              end
            end
            OP_POP: begin
              if (!ring_drained) begin
                slot_nxt  = rslot_r;
                rslot_nxt = rslot_inc;
                cnt_nxt   = '0;
              end
            end
            OP_QUERY: acc_nxt = 1'b1;
            OP_NOP:   acc_nxt = 1'b0;
            default:  acc_nxt = 1'b0;
          endcase

          // arming clears staging through the fill count
          if (do_arm) begin
            fill_nxt  = '0;
            armed_nxt = q_cmd.arm_ok;
            phase_nxt = q_cmd.arm_ok ? PH_REQUEST : PH_ERROR;
            acc_nxt   = q_cmd.arm_ok;
            if (!q_cmd.arm_ok) begin
              inc[CNT_REARM] = 1'b1;
            end
          end
        end
      end
      ST_COPY: begin
        ring_we = (cnt_r != '0);
        if (!copy_end) begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_RESP: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_acc_nxt  = acc_r;
          out_byte_nxt = 8'd0;
          out_last_nxt = 1'b1;
        end
      end
      ST_POP_RD: begin
        out_load = 1'b0;
      end
      ST_POP_EMIT: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_acc_nxt  = 1'b1;
          out_byte_nxt = ring_rdata;
          out_last_nxt = last_byte;
          cnt_nxt      = cnt_r + 1'b1;
        end
      end
      default: begin
        out_load = 1'b0;
      end
    endcase

    for (int i = 0; i < NUM_CNT; i++) begin
      evt_nxt[i] = inc[i] ? evt_r[i] + CNT_W'(1) : evt_r[i];
    end

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= PH_STOPPED;
      armed_r     <= 1'b0;
      fill_r      <= '0;
      wslot_r     <= '0;
      rslot_r     <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_CNT; i++) begin
        evt_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      armed_r     <= armed_nxt;
      fill_r      <= fill_nxt;
      wslot_r     <= wslot_nxt;
      rslot_r     <= rslot_nxt;
      out_valid_r <= out_valid_nxt;
      for (int i = 0; i < NUM_CNT; i++) begin
        evt_r[i] <= evt_nxt[i];
      end
    end
  end

  // payload registers, status sampled when the result is loaded
  always_ff @(posedge clk) begin
    slot_r     <= slot_nxt;
    cnt_r      <= cnt_nxt;
    acc_r      <= acc_nxt;
    out_acc_r  <= out_acc_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
    if (out_load) begin
      out_phase_r <= phase_r;
      out_armed_r <= armed_r;
      out_idle_r  <= ring_drained && ((phase_r == PH_STOPPED) || (phase_r == PH_REQUEST));
      for (int i = 0; i < NUM_CNT; i++) begin
        out_evt_r[i] <= evt_r[i];
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_accepted     = out_acc_r;
  assign out_frame_byte   = out_byte_r;
  assign out_last         = out_last_r;
  assign out_phase_now    = out_phase_r;
  assign out_armed_now    = out_armed_r;
  assign out_idle_now     = out_idle_r;
  assign out_transactions = out_evt_r[CNT_TRANS];
  assign out_overflows    = out_evt_r[CNT_OVF];
  assign out_bus_errors   = out_evt_r[CNT_BUS];
  assign out_rearm_errors = out_evt_r[CNT_REARM];
  assign out_acks         = out_evt_r[CNT_ACK];
  assign out_ack_aborts   = out_evt_r[CNT_ABORT];

endmodule

// ===== rtl/spi_frame_ring_receiver_unit.sv =====
// ----------------------------------------------------------------------------
// spi_frame_ring_receiver_unit
// Collects SPI bytes into frames, keeps a frame ring and event counters.
// ----------------------------------------------------------------------------
// Usage: each request on the in_ channel (valid/stall) carries a kind plus
// its arguments; every request produces result items on the out_ channel,
// the final one flagged by out_last. A pop of a stored frame returns
// FRAME_BYTES items, every other request returns one item with the status
// snapshot taken after the request took effect.
// Requests go through a two-entry queue, so in_stall rises only when the
// queue is full. The execution unit takes the next request only once the
// current one has loaded its last result. A completed transfer that stores
// a frame is first copied byte-wide from staging into the ring memory; a
// pop reads each frame byte from the ring memory and then emits it, as the
// ring memory read is registered.
// While out_stall is high the result register holds and the execution unit
// waits on its next result; the queue keeps taking requests until full.
// Reset clears the phase, arm flag, fill count, ring pointers and counters.
// Ring contents are undefined after reset and need no clearing pass.
// ----------------------------------------------------------------------------
module spi_frame_ring_receiver_unit #(
  parameter int FRAME_BYTES = sfrr_pkg::FRAME_BYTES_DEF,
  parameter int RING_SLOTS  = sfrr_pkg::RING_SLOTS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [3:0]                 in_kind,
  input  logic [7:0]                 in_rx_data,
  input  logic                       in_arm_ok,
  input  logic                       in_deinit_ok,
  input  logic                       in_nss_high,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       out_accepted,
  output logic [7:0]                 out_frame_byte,
  output logic                       out_last,
  output logic [1:0]                 out_phase_now,
  output logic                       out_armed_now,
  output logic                       out_idle_now,
  output logic [sfrr_pkg::CNT_W-1:0] out_transactions,
  output logic [sfrr_pkg::CNT_W-1:0] out_overflows,
  output logic [sfrr_pkg::CNT_W-1:0] out_bus_errors,
  output logic [sfrr_pkg::CNT_W-1:0] out_rearm_errors,
  output logic [sfrr_pkg::CNT_W-1:0] out_acks,
  output logic [sfrr_pkg::CNT_W-1:0] out_ack_aborts
);
  import sfrr_pkg::*;

  cmd_t q_cmd;
  logic q_valid;
  logic q_pop;

  sfrr_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_kind      (in_kind),
    .in_rx_data   (in_rx_data),
    .in_arm_ok    (in_arm_ok),
    .in_deinit_ok (in_deinit_ok),
    .in_nss_high  (in_nss_high),
    .q_cmd        (q_cmd),
    .q_valid      (q_valid),
    .q_pop        (q_pop)
  );

  sfrr_back #(
    .FRAME_BYTES (FRAME_BYTES),
    .RING_SLOTS  (RING_SLOTS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_cmd            (q_cmd),
    .q_valid          (q_valid),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_accepted     (out_accepted),
    .out_frame_byte   (out_frame_byte),
    .out_last         (out_last),
    .out_phase_now    (out_phase_now),
    .out_armed_now    (out_armed_now),
    .out_idle_now     (out_idle_now),
    .out_transactions (out_transactions),
    .out_overflows    (out_overflows),
    .out_bus_errors   (out_bus_errors),
    .out_rearm_errors (out_rearm_errors),
    .out_acks         (out_acks),
    .out_ack_aborts   (out_ack_aborts)
  );

`ifndef SYNTHESIS
  // only frame bytes of a pop come without last, and those are accepted
  a_mid_frame_accepted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> out_accepted)
    else $error("non-final result not accepted");

  a_refused_zero_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_accepted |-> out_frame_byte == 8'd0)
    else $error("refused result carries a frame byte");

  a_armed_in_request: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_armed_now |-> out_phase_now == PH_REQUEST)
    else $error("armed outside request phase");

  a_idle_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_idle_now |->
      (out_phase_now == PH_STOPPED || out_phase_now == PH_REQUEST))
    else $error("idle reported in done or error phase");
`endif

endmodule
